// ===== hdl/jtsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jtsm_pkg
// Types and constants shared by the JTAG TAP shift master.
// ----------------------------------------------------------------------------
package jtsm_pkg;

    localparam int BIB_W = 8;
    localparam int CNT_W = 4;
    localparam int IDX_W = 3;

    localparam logic [BIB_W:0]   BLOCK_BITS = 9'd248;
    localparam logic [CNT_W-1:0] MAX_BITS   = 4'd8;

    localparam logic ACT_TMS   = 1'b0;
    localparam logic ACT_SHIFT = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENTER,
        ST_SYNC,
        ST_DATA,
        ST_EXIT
    } t_state;

    typedef struct packed {
        logic             shift;
        logic [7:0]       data;
        logic [IDX_W-1:0] last_idx;
        logic             open;
        logic             close;
        logic             verify;
        logic [7:0]       cap;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_q_wr;

    typedef struct packed {
        logic full;
        logic empty;
        t_cmd head;
    } t_q_stat;

endpackage
`default_nettype wire

// ===== hdl/jtsm_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jtsm_if
// Valid/ready channels of the shift master: command bytes in, TMS/TDI transfers out.
// ----------------------------------------------------------------------------
interface jtsm_cmd_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;
    logic [3:0] bit_count;
    logic       final_byte;
    logic       verify;
    logic [7:0] tdo_bits;

    modport source (
        output valid, action, data_byte, bit_count, final_byte, verify, tdo_bits,
        input  ready
    );
    modport sink (
        input  valid, action, data_byte, bit_count, final_byte, verify, tdo_bits,
        output ready
    );
endinterface

interface jtsm_tck_if;
    logic       valid;
    logic       ready;
    logic       tms;
    logic       tdi;
    logic       tdi_driven;
    logic       captured_valid;
    logic [7:0] captured_byte;
    logic       last_of_run;

    modport source (
        output valid, tms, tdi, tdi_driven, captured_valid, captured_byte, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, tms, tdi, tdi_driven, captured_valid, captured_byte, last_of_run,
        output ready
    );
endinterface
`default_nettype wire

// ===== hdl/jtsm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jtsm_front
// Accepts command bytes, tracks the open shift block and builds descriptors.
// ----------------------------------------------------------------------------
module jtsm_front import jtsm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    jtsm_cmd_if.sink i_cmd,
    input  logic    i_q_full,
    output t_q_wr   o_q_wr
);

    logic [BIB_W-1:0] r_bib;
    logic [BIB_W-1:0] n_bib;
    logic [CNT_W-1:0] w_cnt;
    logic [CNT_W-1:0] w_shift;
    logic [BIB_W:0]   w_total;
    logic             w_close;
    logic             w_take;

    assign i_cmd.ready = !i_q_full;
    assign w_take      = i_cmd.valid && !i_q_full && (i_cmd.bit_count != '0);

    assign w_cnt   = (i_cmd.bit_count > MAX_BITS) ? MAX_BITS : i_cmd.bit_count;
    assign w_shift = MAX_BITS - w_cnt;
    assign w_total = {1'b0, r_bib} + {{(BIB_W + 1 - CNT_W){1'b0}}, w_cnt};
    assign w_close = i_cmd.final_byte || (w_total >= BLOCK_BITS);

    always_comb begin
        o_q_wr.push          = w_take;
        o_q_wr.cmd.shift     = (i_cmd.action == ACT_SHIFT);
        o_q_wr.cmd.data      = i_cmd.data_byte;
        o_q_wr.cmd.last_idx  = IDX_W'(w_cnt - 4'd1);
        o_q_wr.cmd.open      = (r_bib == '0);
        o_q_wr.cmd.close     = w_close;
        o_q_wr.cmd.verify    = i_cmd.verify;
        o_q_wr.cmd.cap       = i_cmd.tdo_bits << w_shift;
        if ((i_cmd.action == ACT_TMS) || w_close) begin
            n_bib = '0;
        end else begin
            n_bib = w_total[BIB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bib <= '0;
        end else if (w_take) begin
            r_bib <= n_bib;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/jtsm_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jtsm_queue
// Short descriptor queue between the front and the TCK sequencer.
// ----------------------------------------------------------------------------
module jtsm_queue import jtsm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_wr   i_q_wr,
    input  logic    i_pop,
    output t_q_stat o_q_stat
);

    t_cmd              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_q_stat.full  = (r_count == QCNT_W'(Q_DEPTH));
    assign o_q_stat.empty = (r_count == '0);
    assign o_q_stat.head  = r_mem[r_rd_ptr];

    assign w_push = i_q_wr.push && !o_q_stat.full;
    assign w_pop  = i_pop && !o_q_stat.empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_q_wr.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_wr.push |-> !o_q_stat.full)
        else $error("descriptor pushed into full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(Q_DEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== hdl/jtsm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jtsm_back
// TCK sequencer: expands each descriptor into a run of TMS/TDI transfers.
// ----------------------------------------------------------------------------
module jtsm_back import jtsm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    jtsm_tck_if.source o_tck
);

    t_state           r_state;
    t_state           n_state;
    t_cmd             r_cmd;
    t_cmd             n_cmd;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             r_valid;
    logic             n_valid;
    logic             r_tms;
    logic             n_tms;
    logic             r_tdi;
    logic             n_tdi;
    logic             r_drv;
    logic             n_drv;
    logic             r_cap_vld;
    logic             n_cap_vld;
    logic [7:0]       r_cap;
    logic [7:0]       n_cap;
    logic             r_last;
    logic             n_last;
    logic             w_adv;
    logic             w_bit;
    logic             w_is_last;

    assign w_adv     = !r_valid || o_tck.ready;
    assign w_bit     = r_cmd.data[r_idx];
    assign w_is_last = (r_idx == r_cmd.last_idx);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_idx     = r_idx;
        n_valid   = r_valid && !o_tck.ready;
        n_tms     = r_tms;
        n_tdi     = r_tdi;
        n_drv     = r_drv;
        n_cap_vld = r_cap_vld;
        n_cap     = r_cap;
        n_last    = r_last;
        o_pop     = 1'b0;
        if (r_state != ST_IDLE && w_adv) begin
            n_valid   = 1'b1;
            n_drv     = 1'b1;
            n_cap_vld = 1'b0;
            n_cap     = '0;
            n_last    = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_q_stat.head;
                    n_idx   = '0;
                    n_state = (i_q_stat.head.shift && i_q_stat.head.open) ? ST_ENTER : ST_DATA;
                end
            end
            ST_ENTER: begin
                if (w_adv) begin
                    n_tms   = 1'b1;
                    n_tdi   = 1'b1;
                    n_state = ST_SYNC;
                end
            end
            ST_SYNC: begin
                if (w_adv) begin
                    n_tms   = 1'b0;
                    n_tdi   = 1'b0;
                    n_state = ST_DATA;
                end
            end
            ST_DATA: begin
                if (w_adv) begin
                    n_drv = r_cmd.shift;
                    if (r_cmd.shift) begin
                        n_tms = r_cmd.close && w_is_last;
                        n_tdi = w_bit;
                    end else begin
                        n_tms = w_bit;
                        n_tdi = 1'b0;
                    end
                    if (!w_is_last) begin
                        n_idx = r_idx + 1'b1;
                    end else if (r_cmd.shift && r_cmd.close) begin
                        n_state = ST_EXIT;
                    end else begin
                        n_last    = 1'b1;
                        n_cap_vld = r_cmd.shift && r_cmd.verify;
                        n_cap     = (r_cmd.shift && r_cmd.verify) ? r_cmd.cap : '0;
                        n_state   = ST_IDLE;
                    end
                end
            end
            ST_EXIT: begin
                if (w_adv) begin
                    n_tms     = 1'b0;
                    n_tdi     = 1'b1;
                    n_last    = 1'b1;
                    n_cap_vld = r_cmd.verify;
                    n_cap     = r_cmd.verify ? r_cmd.cap : '0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_idx     <= n_idx;
        r_tms     <= n_tms;
        r_tdi     <= n_tdi;
        r_drv     <= n_drv;
        r_cap_vld <= n_cap_vld;
        r_cap     <= n_cap;
        r_last    <= n_last;
    end

    assign o_tck.valid          = r_valid;
    assign o_tck.tms            = r_tms;
    assign o_tck.tdi            = r_tdi;
    assign o_tck.tdi_driven     = r_drv;
    assign o_tck.captured_valid = r_cap_vld;
    assign o_tck.captured_byte  = r_cap;
    assign o_tck.last_of_run    = r_last;

    a_cap_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_cap_vld) |-> (r_last && r_drv))
        else $error("captured byte away from last shift cycle");

    a_enter_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ENTER && w_adv) |=> (r_state == ST_SYNC && r_tms && r_tdi))
        else $error("shift entry sequence broken");

endmodule
`default_nettype wire

// ===== hdl/jtag_tap_shift_master.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jtag_tap_shift_master
// Expands JTAG command bytes into per-cycle TMS/TDI levels with TDO capture.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                                 transfer
//  i_cmd    in   action data_byte bit_count final_byte verify tdo_bits   one command byte
//  o_tck    out  tms tdi tdi_driven captured_valid captured_byte last_of_run one TCK cycle
//
//  A byte yields one TCK transfer per bit, bit count capped at MAX_BITS; in shift mode ENTER and
//  SYNC open a block, EXIT closes it; the back sequencer sends one per cycle while o_tck is ready.
//  The sequencer loads each descriptor from the queue in its idle state, between runs.
//  A byte with a bit count of zero is taken and dropped.
//  Reset is synchronous; it closes any open shift block and empties the queue.
//  Output stalls hold the sequencer; the front keeps taking bytes until the queue fills.
// ----------------------------------------------------------------------------
module jtag_tap_shift_master import jtsm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jtsm_cmd_if.sink   i_cmd,
    jtsm_tck_if.source o_tck
);

    t_q_wr   w_q_wr;
    t_q_stat w_q_stat;
    logic    w_pop;

    jtsm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_q_full (w_q_stat.full),
        .o_q_wr   (w_q_wr)
    );

    jtsm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_wr   (w_q_wr),
        .i_pop    (w_pop),
        .o_q_stat (w_q_stat)
    );

    jtsm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_tck    (o_tck)
    );

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JTAG TAP shift master. A directed table of
// command bytes is walked first, then random TMS paths and shift commands,
// some long enough to split a block, some left unterminated, plus stray bytes.
// Every accepted byte is expanded into the TCK transfers it must produce; each
// TCK transfer is compared field by field against the oldest expected cycle.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top import jtsm_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS   = 140;
    localparam int END_CYCLES   = 40;
    localparam int LIMIT_NS     = 4_000_000;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic [3:0] bit_count;
        logic       final_byte;
        logic       verify;
        logic [7:0] tdo_bits;
    } t_tb_cmd;

    typedef struct packed {
        logic       tms;
        logic       tdi;
        logic       tdi_driven;
        logic       captured_valid;
        logic [7:0] captured_byte;
        logic       last_of_run;
    } t_tb_cycle;

    typedef struct packed {
        t_tb_cmd     c;
        logic        typed;
        logic [3:0]  n_cycles;
        logic [10:0] tms_seq;
        logic [10:0] tdi_seq;
        logic        drv;
        logic        cap_v;
        logic [7:0]  cap;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    jtsm_cmd_if cmd_ch ();
    jtsm_tck_if tck_ch ();

    jtag_tap_shift_master u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_tck   (tck_ch)
    );

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    logic [7:0] open_bits;
    t_tb_cycle  predicted_cycles [$];
    t_tb_cycle  tck_expected [$];
    t_row       cmd_notes [$];
    int         mismatch_count;
    int         items_sent;
    int         src_calm_left;
    int         snk_calm_left;

    function automatic t_tb_cycle mk_cycle(logic tms, logic tdi, logic drv);
        t_tb_cycle t;
        t = '0;
        t.tms        = tms;
        t.tdi        = tdi;
        t.tdi_driven = drv;
        return t;
    endfunction

    function automatic void expand_tck_cycles(t_tb_cmd c);
        logic [3:0]  n;
        logic [8:0]  total;
        logic        closing;
        int unsigned mask;
        predicted_cycles.delete();
        if (c.bit_count == 4'd0) return;
        n = (c.bit_count > MAX_BITS) ? MAX_BITS : c.bit_count;
        if (c.action == ACT_TMS) begin
            open_bits = '0;
            for (int i = 0; i < int'(n); i++)
                predicted_cycles.push_back(mk_cycle(c.data_byte[i], 1'b0, 1'b0));
        end else begin
            total   = {1'b0, open_bits} + 9'(n);
            closing = c.final_byte || (total >= BLOCK_BITS);
            if (open_bits == 8'd0) begin
                predicted_cycles.push_back(mk_cycle(1'b1, 1'b1, 1'b1));
                predicted_cycles.push_back(mk_cycle(1'b0, 1'b0, 1'b1));
            end
            for (int i = 0; i < int'(n); i++)
                predicted_cycles.push_back(mk_cycle(closing && (i == int'(n) - 1),
                                                    c.data_byte[i], 1'b1));
            if (closing) begin
                predicted_cycles.push_back(mk_cycle(1'b0, 1'b1, 1'b1));
                open_bits = '0;
            end else begin
                open_bits = total[7:0];
            end
            if (c.verify) begin
                mask = (32'd1 << n) - 1;
                predicted_cycles[$].captured_valid = 1'b1;
                predicted_cycles[$].captured_byte  = 8'((c.tdo_bits & mask) << (8 - n));
            end
        end
        predicted_cycles[$].last_of_run = 1'b1;
    endfunction

    task automatic flag_mismatch(string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin : mon
        t_row      note;
        t_tb_cmd   c;
        t_tb_cycle got;
        t_tb_cycle want;
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                note = cmd_notes.pop_front();
                c = '{cmd_ch.action, cmd_ch.data_byte, cmd_ch.bit_count,
                      cmd_ch.final_byte, cmd_ch.verify, cmd_ch.tdo_bits};
                expand_tck_cycles(c);
                if (note.typed) begin
                    predicted_cycles.delete();
                    for (int k = 0; k < int'(note.n_cycles); k++) begin
                        want = mk_cycle(note.tms_seq[k], note.tdi_seq[k], note.drv);
                        if (k == int'(note.n_cycles) - 1) begin
                            want.captured_valid = note.cap_v;
                            want.captured_byte  = note.cap;
                            want.last_of_run    = 1'b1;
                        end
                        predicted_cycles.push_back(want);
                    end
                end
                foreach (predicted_cycles[k]) tck_expected.push_back(predicted_cycles[k]);
            end
            if (tck_ch.valid && tck_ch.ready) begin
                got = '{tck_ch.tms, tck_ch.tdi, tck_ch.tdi_driven, tck_ch.captured_valid,
                        tck_ch.captured_byte, tck_ch.last_of_run};
                if (tck_expected.size() == 0) begin
                    flag_mismatch($sformatf("TCK transfer with nothing expected: %h", got));
                end else begin
                    want = tck_expected.pop_front();
                    if (got.tms !== want.tms)
                        flag_mismatch($sformatf("tms %b want %b", got.tms, want.tms));
                    if (got.tdi !== want.tdi)
                        flag_mismatch($sformatf("tdi %b want %b", got.tdi, want.tdi));
                    if (got.tdi_driven !== want.tdi_driven)
                        flag_mismatch($sformatf("tdi_driven %b want %b",
                                                got.tdi_driven, want.tdi_driven));
                    if (got.captured_valid !== want.captured_valid)
                        flag_mismatch($sformatf("captured_valid %b want %b",
                                                got.captured_valid, want.captured_valid));
                    if (got.captured_byte !== want.captured_byte)
                        flag_mismatch($sformatf("captured_byte %h want %h",
                                                got.captured_byte, want.captured_byte));
                    if (got.last_of_run !== want.last_of_run)
                        flag_mismatch($sformatf("last_of_run %b want %b",
                                                got.last_of_run, want.last_of_run));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Clock, reset, limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap(bit sink_side);
        int r;
        if (sink_side && snk_calm_left > 0) begin
            snk_calm_left--;
            return 0;
        end
        if (!sink_side && src_calm_left > 0) begin
            src_calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            if (sink_side) snk_calm_left = $urandom_range(20, 80);
            else src_calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // TCK sink
    // ------------------------------------------------------------------------
    initial begin : sink
        int gap;
        tck_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            gap = pick_gap(1'b1);
            if (gap > 0) begin
                tck_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            tck_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Command source
    // ------------------------------------------------------------------------
    task automatic send_cmd(t_row row);
        int gap;
        gap = pick_gap(1'b0);
        if (gap > 0) begin
            cmd_ch.valid      <= 1'b0;
            cmd_ch.data_byte  <= 8'($urandom);
            cmd_ch.bit_count  <= 4'($urandom);
            cmd_ch.tdo_bits   <= 8'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        cmd_notes.push_back(row);
        cmd_ch.valid      <= 1'b1;
        cmd_ch.action     <= row.c.action;
        cmd_ch.data_byte  <= row.c.data_byte;
        cmd_ch.bit_count  <= row.c.bit_count;
        cmd_ch.final_byte <= row.c.final_byte;
        cmd_ch.verify     <= row.c.verify;
        cmd_ch.tdo_bits   <= row.c.tdo_bits;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        if (row.c.bit_count != 4'd0) items_sent++;
    endtask

    task automatic wait_for_drain();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tck_expected.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_row rand_byte(logic act, logic fin);
        t_row r;
        int   p;
        r = '0;
        p = $urandom_range(0, 99);
        r.c.action     = act;
        r.c.data_byte  = 8'($urandom_range(0, 255));
        r.c.bit_count  = (p < 60) ? 4'd8 : (p < 92) ? 4'($urandom_range(1, 7))
                                                   : 4'($urandom_range(9, 15));
        r.c.final_byte = fin;
        r.c.verify     = 1'($urandom_range(0, 1));
        r.c.tdo_bits   = 8'($urandom_range(0, 255));
        return r;
    endfunction

    //                 act        data   cnt   fin   ver   tdo     typed n  tms      tdi      drv  capv cap
    t_row dir_rows [18] = '{
        '{'{ACT_TMS,   8'hA5, 4'd8,  1'b0, 1'b0, 8'h00}, 1'b1, 4'd8,  11'h0A5, 11'h000, 1'b0, 1'b0, 8'h00},
        '{'{ACT_TMS,   8'h00, 4'd1,  1'b1, 1'b1, 8'hFF}, 1'b1, 4'd1,  11'h000, 11'h000, 1'b0, 1'b0, 8'h00},
        '{'{ACT_SHIFT, 8'hFF, 4'd8,  1'b1, 1'b1, 8'hFF}, 1'b1, 4'd11, 11'h201, 11'h7FD, 1'b1, 1'b1, 8'hFF},
        '{'{ACT_SHIFT, 8'h00, 4'd1,  1'b1, 1'b1, 8'h01}, 1'b1, 4'd4,  11'h005, 11'h009, 1'b1, 1'b1, 8'h80},
        '{'{ACT_SHIFT, 8'hFF, 4'd0,  1'b1, 1'b1, 8'hFF}, 1'b1, 4'd0,  11'h000, 11'h000, 1'b0, 1'b0, 8'h00},
        '{'{ACT_SHIFT, 8'h00, 4'd8,  1'b0, 1'b0, 8'h00}, 1'b0, 4'd0,  11'h000, 11'h000, 1'b0, 1'b0, 8'h00},
        '{'{ACT_SHIFT, 8'h0F, 4'd15, 1'b0, 1'b1, 8'hAA}, 1'b0, 4'd0,  11'h000, 11'h000, 1'b0, 1'b0, 8'h00},
        '{'{ACT_TMS,   8'h1F, 4'd5,  1'b0, 1'b0, 8'h00}, 1'b0, 4'd0,  11'h000, 11'h000, 1'b0, 1'b0, 8'h00},
        '{'{ACT_SHIFT, 8'h3C, 4'd3,  1'b1, 1'b1, 8'hF8}, 1'b0, 4'd0,  11'h000, 11'h000, 1'b0, 1'b0, 8'h00},
        '{'{ACT_SHIFT, 8'h55, 4'd9,  1'b0, 1'b0, 8'h00}, 1'b0, 4'd0,  11'h000, 11'h000, 1'b0, 1'b0, 8'h00},
        '{'{ACT_SHIFT, 8'hAA, 4'd4,  1'b0, 1'b1, 8'h0F}, 1'b0, 4'd0,  11'h000, 11'h000, 1'b0, 1'b0, 8'h00},
        '{'{ACT_SHIFT, 8'h00, 4'd0,  1'b0, 1'b0, 8'h00}, 1'b0, 4'd0,  11'h000, 11'h000, 1'b0, 1'b0, 8'h00},
        '{'{ACT_SHIFT, 8'h81, 4'd8,  1'b1, 1'b1, 8'h81}, 1'b0, 4'd0,  11'h000, 11'h000, 1'b0, 1'b0, 8'h00},
        '{'{ACT_TMS,   8'hFF, 4'd8,  1'b0, 1'b0, 8'h00}, 1'b1, 4'd8,  11'h0FF, 11'h000, 1'b0, 1'b0, 8'h00},
        '{'{ACT_TMS,   8'h00, 4'd15, 1'b1, 1'b0, 8'h00}, 1'b1, 4'd8,  11'h000, 11'h000, 1'b0, 1'b0, 8'h00},
        '{'{ACT_SHIFT, 8'h5A, 4'd7,  1'b1, 1'b0, 8'h00}, 1'b0, 4'd0,  11'h000, 11'h000, 1'b0, 1'b0, 8'h00},
        '{'{ACT_SHIFT, 8'hC3, 4'd12, 1'b0, 1'b1, 8'h3C}, 1'b0, 4'd0,  11'h000, 11'h000, 1'b0, 1'b0, 8'h00},
        '{'{ACT_SHIFT, 8'h7E, 4'd2,  1'b1, 1'b1, 8'h02}, 1'b0, 4'd0,  11'h000, 11'h000, 1'b0, 1'b0, 8'h00}
    };

    initial begin : source
        t_row r;
        int   nbytes;
        int   cmd_index;
        bit   broken;
        bit   drained_mid;
        open_bits         = '0;
        mismatch_count    = 0;
        items_sent        = 0;
        src_calm_left     = 0;
        snk_calm_left     = 0;
        drained_mid       = 1'b0;
        cmd_index         = 0;
        i_rst_n           <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.action     <= ACT_TMS;
        cmd_ch.data_byte  <= '0;
        cmd_ch.bit_count  <= '0;
        cmd_ch.final_byte <= 1'b0;
        cmd_ch.verify     <= 1'b0;
        cmd_ch.tdo_bits   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_cmd(dir_rows[i]);
        wait_for_drain();

        items_sent = 0;
        while (items_sent < RAND_ITEMS) begin
            if (cmd_index > 0 && $urandom_range(0, 99) < 12) begin
                r = '0;
                r.c = t_tb_cmd'($urandom);
                send_cmd(r);
            end else begin
                repeat ($urandom_range(0, 2)) send_cmd(rand_byte(ACT_TMS, 1'($urandom)));
                nbytes = (cmd_index == 0 || $urandom_range(0, 99) < 15)
                         ? $urandom_range(28, 40) : $urandom_range(1, 4);
                broken = ($urandom_range(0, 99) < 10);
                for (int b = 0; b < nbytes; b++)
                    send_cmd(rand_byte(ACT_SHIFT, (b == nbytes - 1) && !broken));
                cmd_index++;
            end
            if (!drained_mid && items_sent >= RAND_ITEMS / 2) begin
                wait_for_drain();
                drained_mid = 1'b1;
            end
        end

        wait_for_drain();
        repeat (END_CYCLES) @(posedge i_clk);
        if (tck_expected.size() != 0)
            flag_mismatch($sformatf("%0d TCK cycles never came", tck_expected.size()));
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
